// ===== hdl/pip_pkg.sv =====
// shared types and constants for the point in convex polygon block
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 16;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 1;
    localparam logic [0:0]  CFG_ORIGIN_X = 1'b0;
    localparam logic [0:0]  CFG_ORIGIN_Y = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEST   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APP_SQ,
        ST_APP_UPD,
        ST_TEST
    } t_state;

endpackage

// ===== hdl/point_in_convex_polygon.sv =====
// point in convex polygon: vertex memory, radius check and edge cross sequencer
// clear, dropped append and test of an empty polygon: result in the cycle after the request
// append: result in the cycle after the request, busy through ST_APP_SQ and ST_APP_UPD (radius update)
// test with n vertices: n+1 memory reads (vertex 0 read again for the closing edge)
//   plus three pipeline stages, busy until the result is given
// the receiver cannot stall results; reset empties the polygon and zeroes the origin
module point_in_convex_polygon #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH,
    localparam int CNTW = $clog2(MAX_VERTICES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_cmd,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output logic                          o_busy,
    output logic                          o_done,
    output logic                          o_inside_res,
    output logic                          o_status,
    output logic [CNTW-1:0]               o_vertex_count,
    input  logic                          i_cfg_we,
    input  logic [pip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int IW   = $clog2(MAX_VERTICES + 2);
    localparam int OPW  = CW + 1;          // point minus origin
    localparam int SQW  = 2 * OPW;         // one square
    localparam int SUMW = SQW + 1;         // squared length
    localparam int MAXW = 2 * CW;          // stored max squared radius
    localparam int AXW  = CW + 2;          // point minus vertex
    localparam int BXW  = CW + 1;          // edge vector
    localparam int PW   = AXW + BXW;       // one cross product term

    pip_pkg::t_state r_state, n_state;

    logic signed [CW-1:0]  r_origin_x, r_origin_y;
    logic [CNTW-1:0]       r_count;
    logic [MAXW-1:0]       r_max;

    logic [2*CW-1:0]       r_mem [MAX_VERTICES];
    logic [2*CW-1:0]       r_rd_data;
    logic [AW-1:0]         rd_addr;

    logic signed [OPW-1:0] r_opx, r_opy;
    logic [SQW-1:0]        r_sqx, r_sqy;
    logic [SUMW-1:0]       len_sq;
    logic                  r_far;

    logic [IW-1:0]         r_issue;
    logic                  issue_en;
    logic                  accept;
    logic                  full;

    logic                  r_s1_vld, r_s1_first, r_s1_last;
    logic signed [CW-1:0]  cur_x, cur_y;
    logic signed [CW-1:0]  r_prev_x, r_prev_y;
    logic                  r_s2_vld, r_s2_last;
    logic signed [AXW-1:0] r_ax, r_ay;
    logic signed [BXW-1:0] r_bx, r_by;
    logic                  r_s3_vld, r_s3_last;
    logic signed [PW-1:0]  r_m1, r_m2;
    logic signed [PW-1:0]  n_m1, n_m2;
    logic signed [PW:0]    cross_val;
    logic                  rej;
    logic                  r_rej_acc;

    assign accept = i_start && !o_busy;
    assign full   = (r_count == CNTW'(MAX_VERTICES));

    // fsm next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pip_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == pip_pkg::CMD_APPEND && !full)
                        n_state = pip_pkg::ST_APP_SQ;
                    else if (i_cmd == pip_pkg::CMD_TEST && r_count != '0)
                        n_state = pip_pkg::ST_TEST;
                end
            end
            pip_pkg::ST_APP_SQ:  n_state = pip_pkg::ST_APP_UPD;
            pip_pkg::ST_APP_UPD: n_state = pip_pkg::ST_IDLE;
            pip_pkg::ST_TEST: begin
                if (r_s3_vld && r_s3_last)
                    n_state = pip_pkg::ST_IDLE;
            end
            default: n_state = pip_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_busy   = 1'b1;
        issue_en = 1'b0;
        case (r_state)
            pip_pkg::ST_IDLE:    o_busy = 1'b0;
            pip_pkg::ST_APP_SQ:  o_busy = 1'b1;
            pip_pkg::ST_APP_UPD: o_busy = 1'b1;
            pip_pkg::ST_TEST:    issue_en = (r_issue <= IW'(r_count));
            default:             o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= pip_pkg::ST_IDLE;
        else
            r_state <= n_state;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pip_pkg::CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                pip_pkg::CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vertex memory, read sequence 0, 1, .., n-1, 0
    assign rd_addr = (r_issue == IW'(r_count)) ? '0 : r_issue[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == pip_pkg::CMD_APPEND && !full)
            r_mem[r_count[AW-1:0]] <= {i_coord_x, i_coord_y};
        r_rd_data <= r_mem[rd_addr];
    end

    // squarer shared by append radius and test length
    assign len_sq = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_cmd == pip_pkg::CMD_TEST) begin
                r_opx <= {i_coord_x[CW-1], i_coord_x} - {r_origin_x[CW-1], r_origin_x};
                r_opy <= {i_coord_y[CW-1], i_coord_y} - {r_origin_y[CW-1], r_origin_y};
            end else begin
                r_opx <= {i_coord_x[CW-1], i_coord_x};
                r_opy <= {i_coord_y[CW-1], i_coord_y};
            end
        end
        r_sqx <= SQW'(r_opx * r_opx);
        r_sqy <= SQW'(r_opy * r_opy);
        r_far <= (len_sq > {{(SUMW-MAXW){1'b0}}, r_max});
    end

    // polygon state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= '0;
        end else begin
            if (accept && i_cmd == pip_pkg::CMD_CLEAR) begin
                r_count <= '0;
                r_max   <= '0;
            end else if (accept && i_cmd == pip_pkg::CMD_APPEND && !full) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == pip_pkg::ST_APP_UPD &&
                len_sq > {{(SUMW-MAXW){1'b0}}, r_max})
                r_max <= len_sq[MAXW-1:0];
        end
    end

    // edge pipeline: read, differences, products, sign test
    assign cur_x = r_rd_data[2*CW-1:CW];
    assign cur_y = r_rd_data[CW-1:0];

    always_comb begin
        n_m1      = r_ax * r_by;
        n_m2      = r_ay * r_bx;
        cross_val = {r_m1[PW-1], r_m1} - {r_m2[PW-1], r_m2};
        rej       = !cross_val[PW] && (cross_val != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_rej_acc  <= 1'b0;
        end else begin
            if (accept)
                r_issue <= '0;
            else if (issue_en)
                r_issue <= r_issue + 1'b1;
            r_s1_vld <= issue_en;
            r_s2_vld <= r_s1_vld && !r_s1_first;
            r_s3_vld <= r_s2_vld;
            if (accept)
                r_rej_acc <= 1'b0;
            else if (r_s3_vld && rej)
                r_rej_acc <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_issue == '0);
        r_s1_last  <= (r_issue == IW'(r_count));
        if (r_s1_vld) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end
        r_s2_last <= r_s1_last;
        r_ax <= {r_opx[OPW-1], r_opx} - {{2{r_prev_x[CW-1]}}, r_prev_x};
        r_ay <= {r_opy[OPW-1], r_opy} - {{2{r_prev_y[CW-1]}}, r_prev_y};
        r_bx <= {cur_x[CW-1], cur_x} - {r_prev_x[CW-1], r_prev_x};
        r_by <= {cur_y[CW-1], cur_y} - {r_prev_y[CW-1], r_prev_y};
        r_s3_last <= r_s2_last;
        r_m1 <= n_m1;
        r_m2 <= n_m2;
    end

    // results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            if (accept && !(i_cmd == pip_pkg::CMD_TEST && r_count != '0)) begin
                o_done         <= 1'b1;
                o_inside_res   <= 1'b0;
                o_status       <= (i_cmd == pip_pkg::CMD_APPEND) && full;
                if (i_cmd == pip_pkg::CMD_CLEAR)
                    o_vertex_count <= '0;
                else if (i_cmd == pip_pkg::CMD_APPEND && !full)
                    o_vertex_count <= r_count + 1'b1;
                else
                    o_vertex_count <= r_count;
            end else if (r_state == pip_pkg::ST_TEST && r_s3_vld && r_s3_last) begin
                o_done         <= 1'b1;
                o_inside_res   <= !r_far && !r_rej_acc && !rej;
                o_status       <= 1'b0;
                o_vertex_count <= r_count;
            end else begin
                o_done <= 1'b0;
            end
        end
    end

endmodule
